// ===== sv/sep7_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep7_pkg
// Shared sizes, types and the 7-tap weighting function of the separable blur.
// ----------------------------------------------------------------------------
package sep7_pkg;

    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;
    localparam int TAPS         = 7;
    localparam int NUM_SLOTS    = TAPS - 1;
    localparam int VALID_W      = IMAGE_WIDTH - NUM_SLOTS;
    localparam int CNT_W        = 12;
    localparam int ADDR_W       = $clog2(VALID_W);
    localparam int SLOT_W       = $clog2(NUM_SLOTS);

    typedef logic [7:0]                    pix_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [SLOT_W-1:0]             slot_t;
    typedef logic [SLOT_W:0]               slot_sum_t;
    typedef logic [NUM_SLOTS-1:0][7:0]     line_word_t;
    typedef logic [TAPS-1:0][7:0]          taps_t;

    localparam cnt_t  LAST_COL   = cnt_t'(IMAGE_WIDTH - 1);
    localparam cnt_t  LAST_ROW   = cnt_t'(IMAGE_HEIGHT - 1);
    localparam cnt_t  FIRST_VAL  = cnt_t'(NUM_SLOTS);
    localparam slot_t LAST_SLOT  = slot_t'(NUM_SLOTS - 1);

    // Weights 2,15,62,98,62,15,2; entry 0 is the oldest sample.
    function automatic pix_t blur7(input taps_t p);
        logic [15:0] s;
        s = 16'(p[0]) * 16'd2  + 16'(p[6]) * 16'd2
          + 16'(p[1]) * 16'd15 + 16'(p[5]) * 16'd15
          + 16'(p[2]) * 16'd62 + 16'(p[4]) * 16'd62
          + 16'(p[3]) * 16'd98;
        return s[15:8];
    endfunction

endpackage

// ===== sv/sep7_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep7_line_mem
// Line store: one word per valid column holding that column's intermediate
// in all six row slots. Registered read; the write merges one slot into the
// word last read.
// ----------------------------------------------------------------------------
module sep7_line_mem (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  sep7_pkg::addr_t       rd_addr,
    output sep7_pkg::line_word_t  rd_word,
    input  logic                  wr_en,
    input  sep7_pkg::addr_t       wr_addr,
    input  sep7_pkg::slot_t       wr_slot,
    input  sep7_pkg::pix_t        wr_pixel
);

    sep7_pkg::line_word_t mem [sep7_pkg::VALID_W];
    sep7_pkg::line_word_t rd_word_reg;
    sep7_pkg::line_word_t merge_word;

    always_comb begin
        merge_word          = rd_word_reg;
        merge_word[wr_slot] = wr_pixel;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= merge_word;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

// ===== sv/separable_7tap_image_blur.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_7tap_image_blur
// 7-tap separable blur (2,15,62,98,62,15,2 >> 8) of an 8-bit raster stream.
// ----------------------------------------------------------------------------
// Input: s_pixel_in in raster order, s_frame_start on the first pixel of a
// frame (zeroes the column and row counters). Output: m_pixel_out for each
// pixel of the valid region (column >= 6 and row >= 6), m_frame_last on the
// last pixel of the frame. Other inputs give no output transfer.
// Throughput: one pixel per cycle while the receiver does not stall. Path
// to m_valid: stage A (tap capture and line read), stage B (horizontal sum
// and line write-back), stage C (vertical sum into the output register).
// The line store is one word per valid column, read and written once per
// pixel, which sets the one-pixel-per-cycle rate.
// Reset clears counters, tap window and pipeline valids; line store contents
// are not cleared, as rows 0..5 of each frame fill it before use.
// When the receiver stalls with a result held, the pipeline freezes and
// s_ready drops until m_ready returns; items without output keep flowing
// while the output register is empty.
// ----------------------------------------------------------------------------
module separable_7tap_image_blur (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sep7_pkg::pix_t       s_pixel_in,
    input  logic                 s_frame_start,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sep7_pkg::pix_t       m_pixel_out,
    output logic                 m_frame_last
);

    logic                 advance;
    logic                 accept;
    sep7_pkg::cnt_t       col_cur;
    sep7_pkg::cnt_t       row_cur;
    sep7_pkg::slot_t      slot_cur;
    sep7_pkg::cnt_t       x_full;
    logic                 h_ok;
    logic                 v_ok;
    logic                 last_cur;

    sep7_pkg::cnt_t       col_reg,  col_next;
    sep7_pkg::cnt_t       row_reg,  row_next;
    sep7_pkg::slot_t      slot_reg, slot_next;
    sep7_pkg::pix_t       win_reg [sep7_pkg::NUM_SLOTS];

    logic                 valid_a_reg;
    logic                 out_a_reg;
    logic                 last_a_reg;
    sep7_pkg::taps_t      taps_a_reg;
    sep7_pkg::addr_t      addr_a_reg;
    sep7_pkg::slot_t      slot_a_reg;

    sep7_pkg::pix_t       h_b;
    sep7_pkg::line_word_t rd_word;

    logic                 valid_c_reg;
    logic                 last_c_reg;
    sep7_pkg::pix_t       h_c_reg;
    sep7_pkg::line_word_t word_c_reg;
    sep7_pkg::slot_t      slot_c_reg;
    sep7_pkg::taps_t      vtaps;

    logic                 m_valid_reg;
    sep7_pkg::pix_t       m_pixel_reg;
    logic                 m_last_reg;

    logic                 rd_en;
    logic                 wr_en;
    sep7_pkg::addr_t      rd_addr;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // Stage 0: position of the incoming pixel
    always_comb begin
        col_cur  = s_frame_start ? '0 : col_reg;
        row_cur  = s_frame_start ? '0 : row_reg;
        slot_cur = s_frame_start ? '0 : slot_reg;
        x_full   = col_cur - sep7_pkg::FIRST_VAL;
        h_ok     = col_cur >= sep7_pkg::FIRST_VAL;
        v_ok     = h_ok && (row_cur >= sep7_pkg::FIRST_VAL);
        last_cur = (col_cur == sep7_pkg::LAST_COL) && (row_cur == sep7_pkg::LAST_ROW);
        rd_addr  = x_full[sep7_pkg::ADDR_W-1:0];
        rd_en    = accept && h_ok;

        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (accept) begin
            if (col_cur == sep7_pkg::LAST_COL) begin
                col_next = '0;
                if (row_cur == sep7_pkg::LAST_ROW) begin
                    row_next  = '0;
                    slot_next = '0;
                end else begin
                    row_next  = row_cur + 1'b1;
                    slot_next = (slot_cur == sep7_pkg::LAST_SLOT) ? '0 : slot_cur + 1'b1;
                end
            end else begin
                col_next  = col_cur + 1'b1;
                row_next  = row_cur;
                slot_next = slot_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            for (int i = 0; i < sep7_pkg::NUM_SLOTS; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            if (accept) begin
                for (int i = 0; i < sep7_pkg::NUM_SLOTS - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[sep7_pkg::NUM_SLOTS-1] <= s_pixel_in;
            end
        end
    end

    // Stage A: capture taps, issue line read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (advance) begin
            valid_a_reg <= accept && h_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < sep7_pkg::NUM_SLOTS; i++) begin
                taps_a_reg[i] <= win_reg[i];
            end
            taps_a_reg[sep7_pkg::TAPS-1] <= s_pixel_in;
            out_a_reg  <= v_ok;
            last_a_reg <= last_cur;
            addr_a_reg <= rd_addr;
            slot_a_reg <= slot_cur;
        end
    end

    // Stage B: horizontal pass, write intermediate back into its row slot
    assign h_b   = sep7_pkg::blur7(taps_a_reg);
    assign wr_en = advance && valid_a_reg;

    sep7_line_mem u_line_mem (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_word  (rd_word),
        .wr_en    (wr_en),
        .wr_addr  (addr_a_reg),
        .wr_slot  (slot_a_reg),
        .wr_pixel (h_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_c_reg <= 1'b0;
        end else if (advance) begin
            valid_c_reg <= valid_a_reg && out_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && valid_a_reg) begin
            h_c_reg    <= h_b;
            word_c_reg <= rd_word;
            slot_c_reg <= slot_a_reg;
            last_c_reg <= last_a_reg;
        end
    end

    // Stage C: order the six stored rows oldest first, add the current row
    always_comb begin
        sep7_pkg::slot_sum_t s;
        for (int i = 0; i < sep7_pkg::NUM_SLOTS; i++) begin
            s = sep7_pkg::slot_sum_t'(slot_c_reg) + sep7_pkg::slot_sum_t'(i);
            if (s >= sep7_pkg::slot_sum_t'(sep7_pkg::NUM_SLOTS)) begin
                s = s - sep7_pkg::slot_sum_t'(sep7_pkg::NUM_SLOTS);
            end
            vtaps[i] = word_c_reg[s[sep7_pkg::SLOT_W-1:0]];
        end
        vtaps[sep7_pkg::TAPS-1] = h_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= valid_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && valid_c_reg) begin
            m_pixel_reg <= sep7_pkg::blur7(vtaps);
            m_last_reg  <= last_c_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && wr_en |-> rd_addr != addr_a_reg)
        else $error("line store read and write hit the same column");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= sep7_pkg::LAST_COL && row_reg <= sep7_pkg::LAST_ROW)
        else $error("position counter out of frame");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= sep7_pkg::LAST_SLOT)
        else $error("row slot out of range");

    a_out_needs_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_a_reg |=> !valid_c_reg || !$past(advance))
        else $error("stage C loaded without stage A item");

endmodule

// ===== tb/sv/separable_7tap_image_blur_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_7tap_image_blur_tb
// Self-checking bench for the 7-tap separable blur over a raster pixel stream.
// ----------------------------------------------------------------------------
// A queue of pixels feeds a valid/ready driver; every accepted pixel runs
// through a behavioral blur that keeps its own tap history, line rows and
// position counters, and queues the filtered pixel it should produce. The
// monitor pops that queue on each output transfer and compares both fields.
// Stimulus: a few directed pixels with broken partial frames, then one frame
// filled with random pixels into row six, continued across three idling
// phases without a frame start. One long receiver hold-off, and a drain
// between phases.
// ----------------------------------------------------------------------------
module separable_7tap_image_blur_tb;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [6:0][7:0] BLUR_WT = {8'd2, 8'd15, 8'd62, 8'd98, 8'd62, 8'd15, 8'd2};

    typedef struct packed {
        sep7_pkg::pix_t pix;
        logic           start;
    } px_item_t;

    typedef struct packed {
        sep7_pkg::pix_t pix;
        logic           last;
    } blur_out_t;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_EXTREME, FILL_BANDED} fill_t;

    logic           aclk          = 1'b0;
    logic           aresetn       = 1'b0;
    logic           s_valid       = 1'b0;
    logic           s_ready;
    sep7_pkg::pix_t s_pixel_in    = '0;
    logic           s_frame_start = 1'b0;
    logic           m_valid;
    logic           m_ready       = 1'b0;
    sep7_pkg::pix_t m_pixel_out;
    logic           m_frame_last;

    px_item_t    pixel_q[$];
    blur_out_t   blur_exp_q[$];
    px_item_t    next_px;
    blur_out_t   want;

    sep7_pkg::pix_t tap_hist [sep7_pkg::NUM_SLOTS];
    sep7_pkg::pix_t row_lines [sep7_pkg::NUM_SLOTS][sep7_pkg::VALID_W];
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;

    logic        s_took    = 1'b0;
    int          s_idle_pct = 10;
    int          m_idle_pct = 87;
    int          hold_reqs  = 0;
    int          hold_done  = 0;
    int          hold_left  = 0;
    int unsigned got_cnt    = 0;
    int unsigned err_cnt    = 0;
    int          stall_cyc  = 0;

    separable_7tap_image_blur i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_frame_last  (m_frame_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_err(input string msg);
        err_cnt++;
        $display("MISMATCH: %s", msg);
    endtask

    function automatic void blur_predict(input sep7_pkg::pix_t pix, input logic start);
        int unsigned    hsum;
        int unsigned    vsum;
        int unsigned    x;
        int unsigned    k;
        int unsigned    slot;
        sep7_pkg::pix_t h;
        blur_out_t      o;
        if (start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= sep7_pkg::NUM_SLOTS) begin
            x = col_cnt - sep7_pkg::NUM_SLOTS;
            hsum = 32'(BLUR_WT[6]) * 32'(pix);
            for (k = 0; k < sep7_pkg::NUM_SLOTS; k++) begin
                hsum += 32'(BLUR_WT[k]) * 32'(tap_hist[k]);
            end
            h = sep7_pkg::pix_t'(hsum >> 8);
            if (row_cnt >= sep7_pkg::NUM_SLOTS) begin
                vsum = 32'(BLUR_WT[6]) * 32'(h);
                for (k = 0; k < sep7_pkg::NUM_SLOTS; k++) begin
                    slot = (row_cnt - sep7_pkg::NUM_SLOTS + k) % sep7_pkg::NUM_SLOTS;
                    vsum += 32'(BLUR_WT[k]) * 32'(row_lines[slot][x]);
                end
                o.pix  = sep7_pkg::pix_t'(vsum >> 8);
                o.last = (row_cnt == sep7_pkg::IMAGE_HEIGHT - 1) &&
                         (col_cnt == sep7_pkg::IMAGE_WIDTH - 1);
                blur_exp_q.push_back(o);
            end
            row_lines[row_cnt % sep7_pkg::NUM_SLOTS][x] = h;
        end
        for (k = 0; k < sep7_pkg::NUM_SLOTS - 1; k++) begin
            tap_hist[k] = tap_hist[k + 1];
        end
        tap_hist[sep7_pkg::NUM_SLOTS - 1] = pix;
        if (col_cnt + 1 >= sep7_pkg::IMAGE_WIDTH) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= sep7_pkg::IMAGE_HEIGHT) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endfunction

    task automatic queue_px(input sep7_pkg::pix_t pix, input logic start);
        px_item_t it;
        it.pix   = pix;
        it.start = start;
        pixel_q.push_back(it);
    endtask

    task automatic queue_frame_run(input int unsigned npix, input fill_t fill);
        int unsigned    i;
        fill_t          mode;
        sep7_pkg::pix_t p;
        mode = fill;
        for (i = 0; i < npix; i++) begin
            if (fill == FILL_BANDED && i % (8 * sep7_pkg::IMAGE_WIDTH) == 0) begin
                mode = fill_t'($urandom_range(FILL_EXTREME));
            end
            case (mode)
                FILL_ZERO:    p = 8'd0;
                FILL_FULL:    p = 8'd255;
                FILL_EXTREME: p = $urandom_range(1) ? 8'd255 : 8'd0;
                default:      p = sep7_pkg::pix_t'($urandom);
            endcase
            queue_px(p, i == 0);
        end
    endtask

    task automatic queue_noise(input int unsigned n, input int start_pct);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            queue_px(sep7_pkg::pix_t'($urandom), $urandom_range(99) < start_pct);
        end
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_valid || blur_exp_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_took)) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                next_px = pixel_q.pop_front();
                s_valid       <= 1'b1;
                s_pixel_in    <= next_px.pix;
                s_frame_start <= next_px.start;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_reqs != hold_done) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took    <= 1'b0;
            stall_cyc <= 0;
        end else begin
            s_took <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (blur_exp_q.size() == 0) begin
                    report_err($sformatf("unexpected output pixel_out=%0d frame_last=%0b",
                                         m_pixel_out, m_frame_last));
                end else begin
                    want = blur_exp_q.pop_front();
                    if (m_pixel_out !== want.pix) begin
                        report_err($sformatf("result %0d: pixel_out=%0d, want %0d",
                                             got_cnt, m_pixel_out, want.pix));
                    end
                    if (m_frame_last !== want.last) begin
                        report_err($sformatf("result %0d: frame_last=%0b, want %0b",
                                             got_cnt, m_frame_last, want.last));
                    end
                end
                got_cnt++;
            end
            if (s_valid && s_ready) begin
                blur_predict(s_pixel_in, s_frame_start);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cyc <= 0;
            end else if (stall_cyc >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cyc <= stall_cyc + 1;
            end
        end
    end

    initial begin
        int unsigned base;
        for (int k = 0; k < sep7_pkg::NUM_SLOTS; k++) begin
            tap_hist[k] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver mostly stalls
        s_idle_pct = 10;
        m_idle_pct = 87;
        queue_px(8'd255, 1'b1);
        queue_px(8'd0,   1'b0);
        queue_px(8'd255, 1'b0);
        queue_px(8'd0,   1'b0);
        queue_px(8'h55,  1'b0);
        queue_px(8'hAA,  1'b0);
        queue_px(8'd1,   1'b0);
        queue_px(8'd128, 1'b0);
        queue_px(8'd254, 1'b0);
        queue_px(8'd127, 1'b0);
        queue_px(8'd255, 1'b1);
        queue_px(8'd0,   1'b0);
        queue_px(8'd255, 1'b0);
        queue_px(8'd0,   1'b1);
        queue_frame_run(6 * sep7_pkg::IMAGE_WIDTH + 70, FILL_RANDOM);
        wait_drained();

        // sender mostly idle, receiver lightly stalls; continue the same row
        s_idle_pct = 87;
        m_idle_pct = 10;
        queue_noise(60, 0);
        wait_drained();

        // no idling; hold off the receiver while the sender keeps offering
        s_idle_pct = 0;
        m_idle_pct = 0;
        base = got_cnt;
        queue_noise(100, 0);
        while (got_cnt < base + 10) begin
            @(posedge aclk);
        end
        hold_reqs = hold_reqs + 1;
        wait_drained();

        repeat (8) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
